@@ hw/rtl/pkvs_pkg.sv @@
// Package for the packed key/value store: transaction types, opcodes,
// status codes and byte constants. No dependencies.
package pkvs_pkg;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  char_in;
    logic [9:0]  address;
    logic [15:0] buffer_len;
  } pkvs_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] value_offset;
    logic [9:0] value_length;
    logic [7:0] read_byte;
  } pkvs_out_t;

  localparam logic [2:0] OP_KEY  = 3'd0;
  localparam logic [2:0] OP_VAL  = 3'd1;
  localparam logic [2:0] OP_GET  = 3'd2;
  localparam logic [2:0] OP_SET  = 3'd3;
  localparam logic [2:0] OP_LOAD = 3'd4;
  localparam logic [2:0] OP_READ = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_NOSPACE  = 2'd2;
  localparam logic [1:0] ST_BADKEY   = 2'd3;

  localparam logic [7:0] CH_EQ = 8'h3d;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7a;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LA && c <= CH_LZ) r = c & ~8'h20;
    return r;
  endfunction

endpackage

@@ hw/rtl/pkvs_stage.sv @@
// Staging buffers for key and value bytes, with a registered read port each.
// Depends on pkvs_pkg.
module pkvs_stage #(
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);
  import pkvs_pkg::*;

  logic [7:0] mem [Depth];

  // write one byte, read one byte a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ hw/rtl/pkvs_store.sv @@
// Byte store with one write and one registered read port.
// Depends on pkvs_pkg.
module pkvs_store #(
  parameter int Bytes = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Bytes)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic [$clog2(Bytes)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);
  import pkvs_pkg::*;

  logic [7:0] mem [Bytes];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ hw/rtl/packed_key_value_store.sv @@
// Packed key/value store: byte store of KEY=VALUE entries with a sequencer.
// Depends on pkvs_pkg, pkvs_stage, pkvs_store.
//
// One transaction at a time. Key/value bytes and loads pass through S_OUT
// before their result is valid; a read first passes through S_RD for the
// registered store byte. A get scans the store through the single read
// port, skipping bytes inside an entry and comparing bytes that start a
// candidate entry. A set does the same scan, walks down from the top for
// the free area, compacts in place by copying bytes through the store ports
// and zero-filling the freed tail and, unless the value is empty, appends
// the new entry.
// After reset a clearing pass writes zero to every store byte, during which
// in_stall_o stays high.
module packed_key_value_store #(
  parameter int STORE_BYTES = 1024,
  parameter int MAX_KEY     = 64,
  parameter int MAX_VALUE   = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pkvs_pkg::pkvs_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pkvs_pkg::pkvs_out_t out_data_o
);
  import pkvs_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam int PW = AW + 1;
  localparam int KW = $clog2(MAX_KEY);
  localparam int VW = $clog2(MAX_VALUE);
  localparam int KC = KW + 1;
  localparam int VC = VW + 1;
  localparam logic [PW-1:0] SB = PW'(STORE_BYTES);

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RD    = 5'd2;
  localparam logic [4:0] S_OUT   = 5'd3;
  localparam logic [4:0] S_FSTRT = 5'd4;  // start candidate at p
  localparam logic [4:0] S_FCMP  = 5'd5;  // issue reads st[p+i], key[i]
  localparam logic [4:0] S_FCHK  = 5'd6;  // compare
  localparam logic [4:0] S_FSKIP = 5'd7;  // advance p to after next zero
  localparam logic [4:0] S_FSKW  = 5'd8;
  localparam logic [4:0] S_VLEN  = 5'd9;
  localparam logic [4:0] S_VLW   = 5'd10;
  localparam logic [4:0] S_DONEF = 5'd11;
  localparam logic [4:0] S_SCMP  = 5'd12; // compare old value with stage
  localparam logic [4:0] S_SCMW  = 5'd13;
  localparam logic [4:0] S_FREE  = 5'd14; // find last nonzero from top
  localparam logic [4:0] S_FRW   = 5'd15;
  localparam logic [4:0] S_MOVR  = 5'd16;
  localparam logic [4:0] S_MOVW  = 5'd17;
  localparam logic [4:0] S_ZERO  = 5'd18;
  localparam logic [4:0] S_APK   = 5'd19;
  localparam logic [4:0] S_APKW  = 5'd20;
  localparam logic [4:0] S_APV   = 5'd21;
  localparam logic [4:0] S_APVW  = 5'd22;
  localparam logic [4:0] S_APE   = 5'd23;
  localparam logic [4:0] S_SPCK  = 5'd24; // space check

  logic [4:0]     state_q, state_d;
  pkvs_in_t       req_q, req_d;
  pkvs_out_t      res_q, res_d;
  logic           ovalid_q, ovalid_d;
  logic [KC-1:0]  kcnt_q, kcnt_d;
  logic [VC-1:0]  vcnt_q, vcnt_d;
  logic           ovf_q, ovf_d;
  logic [PW-1:0]  p_q, p_d;     // candidate entry start / generic pointer
  logic [PW-1:0]  i_q, i_d;     // counter
  logic [PW-1:0]  vp_q, vp_d;   // value start
  logic [PW-1:0]  past_q, past_d;
  logic [PW-1:0]  f_q, f_d;
  logic           found_q, found_d;

  // store port
  logic          st_we;
  logic [AW-1:0] st_wa, st_ra;
  logic [7:0]    st_wd, st_rd;
  // stage ports
  logic          k_we, v_we;
  logic [KW-1:0] k_wa, k_ra;
  logic [VW-1:0] v_wa, v_ra;
  logic [7:0]    k_rd, v_rd;

  pkvs_store #(.Bytes(STORE_BYTES)) u_store (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd),
    .raddr_i(st_ra), .rdata_o(st_rd));
  pkvs_stage #(.Depth(MAX_KEY)) u_key (
    .clk_i, .we_i(k_we), .waddr_i(k_wa), .wdata_i(in_data_i.char_in),
    .raddr_i(k_ra), .rdata_o(k_rd));
  pkvs_stage #(.Depth(MAX_VALUE)) u_val (
    .clk_i, .we_i(v_we), .waddr_i(v_wa), .wdata_i(in_data_i.char_in),
    .raddr_i(v_ra), .rdata_o(v_rd));

  assign in_stall_o  = (state_q != S_IDLE) || ovalid_q;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = res_q;

  logic [PW-1:0] pk;     // p + key_count
  logic [PW-1:0] old_len;
  logic [PW:0]   need;
  logic [15:0]   lim;
  assign pk      = p_q + PW'(kcnt_q);
  assign old_len = i_q;
  assign need    = (PW+1)'(kcnt_q) + (PW+1)'(vcnt_q) + (PW+1)'(2);
  assign lim     = (req_q.buffer_len == 16'd0) ? '0 : req_q.buffer_len - 16'd1;

  // sequencer
  always_comb begin
    logic [16:0] vl;
    state_d = state_q; req_d = req_q; res_d = res_q; ovalid_d = ovalid_q;
    kcnt_d = kcnt_q; vcnt_d = vcnt_q; ovf_d = ovf_q;
    p_d = p_q; i_d = i_q; vp_d = vp_q; past_d = past_q; f_d = f_q;
    found_d = found_q;
    st_we = 1'b0; st_wa = p_q[AW-1:0]; st_wd = '0; st_ra = p_q[AW-1:0];
    k_we = 1'b0; v_we = 1'b0;
    k_wa = kcnt_q[KW-1:0]; v_wa = vcnt_q[VW-1:0];
    k_ra = i_q[KW-1:0]; v_ra = i_q[VW-1:0];
    vl = '0;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    case (state_q)
      S_CLR: begin
        st_we = 1'b1; st_wa = i_q[AW-1:0];
        i_d = i_q + 1'b1;
        if (i_q == SB - 1'b1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          req_d = in_data_i;
          res_d = '0;
          state_d = S_OUT;
          case (in_data_i.opcode)
            OP_KEY, OP_VAL: begin
              if (in_data_i.char_in != 8'd0) begin
                if (in_data_i.opcode == OP_KEY) begin
                  if (kcnt_q < KC'(MAX_KEY)) begin
                    k_we = 1'b1; k_wa = kcnt_q[KW-1:0]; kcnt_d = kcnt_q + 1'b1;
                  end else begin
                    ovf_d = 1'b1; res_d.status = ST_BADKEY;
                  end
                end else begin
                  if (vcnt_q < VC'(MAX_VALUE)) begin
                    v_we = 1'b1; v_wa = vcnt_q[VW-1:0]; vcnt_d = vcnt_q + 1'b1;
                  end else begin
                    ovf_d = 1'b1; res_d.status = ST_BADKEY;
                  end
                end
              end
            end
            OP_GET, OP_SET: begin
              if (kcnt_q == '0 || ovf_q) begin
                res_d.status = ST_BADKEY;
                kcnt_d = '0; vcnt_d = '0; ovf_d = 1'b0;
              end else begin
                p_d = '0; found_d = 1'b0; state_d = S_FSTRT;
              end
            end
            OP_LOAD: begin
              if (PW'(in_data_i.address) < SB) begin
                st_we = 1'b1; st_wa = AW'(in_data_i.address);
                st_wd = in_data_i.char_in;
              end
            end
            OP_READ: begin
              st_ra = AW'(in_data_i.address);
              state_d = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        if (PW'(req_q.address) < SB) res_d.read_byte = st_rd;
        state_d = S_OUT;
      end
      S_OUT: begin
        ovalid_d = 1'b1; state_d = S_IDLE;
      end
      S_FSTRT: begin
        if (pk >= SB) state_d = S_DONEF;
        else begin
          i_d = '0; state_d = S_FCMP;
        end
      end
      S_FCMP: begin
        st_ra = AW'(p_q + i_q); k_ra = i_q[KW-1:0];
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (i_q == PW'(kcnt_q)) begin
          if (st_rd == CH_EQ) begin
            found_d = 1'b1; vp_d = pk + 1'b1; i_d = '0; state_d = S_VLEN;
          end else begin
            i_d = '0; state_d = S_FSKIP;
          end
        end else if (st_rd != to_upper(k_rd)) begin
          i_d = '0; state_d = S_FSKIP;
        end else begin
          i_d = i_q + 1'b1; state_d = S_FCMP;
        end
      end
      S_FSKIP: begin
        // scan forward for the zero that ends this candidate
        st_ra = p_q[AW-1:0];
        p_d = p_q + 1'b1;
        state_d = S_FSKW;
      end
      S_FSKW: begin
        if (p_q >= SB) state_d = S_DONEF;
        else if (st_rd == 8'd0) state_d = S_FSTRT;
        else state_d = S_FSKIP;
      end
      S_VLEN: begin
        if (vp_q + i_q >= SB) state_d = S_DONEF;
        else begin
          st_ra = AW'(vp_q + i_q); state_d = S_VLW;
        end
      end
      S_VLW: begin
        if (st_rd == 8'd0) state_d = S_DONEF;
        else begin
          i_d = i_q + 1'b1; state_d = S_VLEN;
        end
      end
      S_DONEF: begin
        if (req_q.opcode == OP_GET) begin
          if (found_q) begin
            vl = 17'(old_len);
            if (vl > 17'(lim)) vl = 17'(lim);
            if (vl > 17'd1023) vl = 17'd1023;
            res_d.value_offset = vp_q[9:0];
            res_d.value_length = vl[9:0];
          end else res_d.status = ST_NOTFOUND;
          kcnt_d = '0; vcnt_d = '0; ovf_d = 1'b0; state_d = S_OUT;
        end else begin
          past_d = (vp_q + old_len + 1'b1 > SB) ? SB : vp_q + old_len + 1'b1;
          if (!found_q && vcnt_q == '0) begin
            kcnt_d = '0; vcnt_d = '0; ovf_d = 1'b0; state_d = S_OUT;
          end else if (found_q && old_len == PW'(vcnt_q)) begin
            i_d = '0; state_d = S_SCMP;
          end else begin
            i_d = SB; f_d = '0; state_d = S_FREE;
          end
        end
      end
      S_SCMP: begin
        if (i_q == PW'(vcnt_q)) begin
          kcnt_d = '0; vcnt_d = '0; ovf_d = 1'b0; state_d = S_OUT;
        end else begin
          st_ra = AW'(vp_q + i_q); v_ra = i_q[VW-1:0]; state_d = S_SCMW;
        end
      end
      S_SCMW: begin
        if (st_rd != v_rd) begin
          i_d = SB; f_d = '0; state_d = S_FREE;
        end else begin
          i_d = i_q + 1'b1; state_d = S_SCMP;
        end
      end
      S_FREE: begin
        // walk down from the top, skip the entry that is being removed
        if (i_q == '0) begin
          f_d = '0; state_d = S_SPCK;
        end else if (found_q && i_q > p_q && i_q <= past_q) begin
          i_d = p_q;
        end else begin
          st_ra = AW'(i_q - 1'b1); state_d = S_FRW;
        end
      end
      S_FRW: begin
        // free area starts two bytes past the last nonzero byte after removal
        if (st_rd != 8'd0) begin
          f_d = (found_q && i_q > past_q) ? i_q + 1'b1 - (past_q - p_q) : i_q + 1'b1;
          state_d = S_SPCK;
        end else begin
          i_d = i_q - 1'b1; state_d = S_FREE;
        end
      end
      S_SPCK: begin
        // a delete needs no space; otherwise drop the set when it cannot fit
        if (!(found_q && vcnt_q == '0) &&
            (f_q > SB || (PW+1)'(SB - f_q) < need)) begin
          res_d.status = ST_NOSPACE;
          kcnt_d = '0; vcnt_d = '0; ovf_d = 1'b0; state_d = S_OUT;
        end else begin
          i_d = past_q; state_d = S_MOVR;
        end
      end
      S_MOVR: begin
        if (!found_q || i_q >= SB) begin
          i_d = found_q ? SB - (past_q - p_q) : SB;
          state_d = S_ZERO;
        end else begin
          st_ra = i_q[AW-1:0]; state_d = S_MOVW;
        end
      end
      S_MOVW: begin
        st_we = 1'b1; st_wa = AW'(i_q - (past_q - p_q)); st_wd = st_rd;
        i_d = i_q + 1'b1; state_d = S_MOVR;
      end
      S_ZERO: begin
        if (i_q >= SB) begin
          if (found_q && vcnt_q == '0) begin
            kcnt_d = '0; vcnt_d = '0; ovf_d = 1'b0; state_d = S_OUT;
          end else begin
            i_d = '0; state_d = S_APK;
          end
        end else begin
          st_we = 1'b1; st_wa = i_q[AW-1:0]; st_wd = '0; i_d = i_q + 1'b1;
        end
      end
      S_APK: begin
        if (i_q == PW'(kcnt_q)) begin
          st_we = 1'b1; st_wa = f_q[AW-1:0]; st_wd = CH_EQ;
          f_d = f_q + 1'b1; i_d = '0; state_d = S_APV;
        end else begin
          k_ra = i_q[KW-1:0]; state_d = S_APKW;
        end
      end
      S_APKW: begin
        st_we = 1'b1; st_wa = f_q[AW-1:0]; st_wd = to_upper(k_rd);
        f_d = f_q + 1'b1; i_d = i_q + 1'b1; state_d = S_APK;
      end
      S_APV: begin
        if (i_q == PW'(vcnt_q)) state_d = S_APE;
        else begin
          v_ra = i_q[VW-1:0]; state_d = S_APVW;
        end
      end
      S_APVW: begin
        st_we = 1'b1; st_wa = f_q[AW-1:0]; st_wd = v_rd;
        f_d = f_q + 1'b1; i_d = i_q + 1'b1; state_d = S_APV;
      end
      S_APE: begin
        st_we = 1'b1; st_wa = f_q[AW-1:0]; st_wd = '0;
        kcnt_d = '0; vcnt_d = '0; ovf_d = 1'b0; state_d = S_OUT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR; ovalid_q <= 1'b0; kcnt_q <= '0; vcnt_q <= '0;
      ovf_q <= 1'b0; i_q <= '0;
    end else begin
      state_q <= state_d; ovalid_q <= ovalid_d; kcnt_q <= kcnt_d;
      vcnt_q <= vcnt_d; ovf_q <= ovf_d; i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d; res_q <= res_d; p_q <= p_d; vp_q <= vp_d;
    past_q <= past_d; f_q <= f_d; found_q <= found_d;
  end
endmodule

@@ hw/rtl/pkvs_checker.sv @@
// Port checker for the packed key/value store, bound to the top level.
// Depends on pkvs_pkg.
module pkvs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pkvs_pkg::pkvs_out_t out_data_o
);
  import pkvs_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed under stall");

  // no new transaction while a result waits
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  // an accepted transaction yields no result in the next cycle
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !out_valid_o)
    else $error("result too early");

  // get results carry no read byte, reads carry no length
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.read_byte == 8'd0 || out_data_o.value_length == 10'd0))
    else $error("mixed result fields");
endmodule

bind packed_key_value_store pkvs_checker u_pkvs_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o);

@@ tb/tb.sv @@
// Testbench for packed_key_value_store: directed table then random traffic,
// every result checked against an in-bench model of the store. Uses pkvs_pkg.
`timescale 1ns / 1ps

module tb;
  import pkvs_pkg::*;

  localparam int NBYTES   = 1024;
  localparam int KEY_CAP  = 64;
  localparam int VAL_CAP  = 256;
  localparam int N_ITEMS  = 280;
  localparam int WD_LIMIT = 200000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  pkvs_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  pkvs_out_t out_data_o;

  packed_key_value_store uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  // Shadow of the store and staging buffers
  logic [7:0] kv_mem [NBYTES];
  logic [7:0] kv_tmp [NBYTES];
  logic [7:0] key_buf [KEY_CAP];
  logic [7:0] val_buf [VAL_CAP];
  int         key_len;
  int         val_len;
  bit         stage_ovf;

  pkvs_out_t expected_q [$];
  int        err_count;
  bit        quiet_tail;
  int        idle_cycles;
  int        sent;

  initial clk_i = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) ? (c & 8'hdf) : c;
  endfunction

  // Search for the staged key; return entry start and value start
  function automatic bit lookup_key(output int ent, output int vpos);
    bit ok;
    ent = 0;
    vpos = 0;
    for (int p = 0; p < NBYTES; p++) begin
      if (p != 0 && kv_mem[p-1] != 8'h00) continue;
      if (p + key_len >= NBYTES) return 1'b0;
      ok = 1'b1;
      for (int i = 0; i < key_len; i++)
        if (kv_mem[p+i] != upcase(key_buf[i])) begin
          ok = 1'b0;
          break;
        end
      if (ok && kv_mem[p+key_len] == CH_EQ) begin
        ent = p;
        vpos = p + key_len + 1;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic int value_span(int off);
    int n;
    n = 0;
    while (off + n < NBYTES && kv_mem[off+n] != 8'h00) n++;
    return n;
  endfunction

  // Insert, replace or delete the staged entry
  function automatic logic [1:0] apply_set();
    int  ent, vpos, old, past, f, need;
    bit  hit, same;
    hit = lookup_key(ent, vpos);
    if (!hit && val_len == 0) return ST_OK;
    for (int i = 0; i < NBYTES; i++) kv_tmp[i] = kv_mem[i];
    if (hit) begin
      old = value_span(vpos);
      same = (old == val_len);
      for (int i = 0; i < old && same; i++)
        if (kv_mem[vpos+i] != val_buf[i]) same = 1'b0;
      if (same) return ST_OK;
      past = vpos + old + 1;
      if (past > NBYTES) past = NBYTES;
      for (int i = 0; i < NBYTES - past; i++) kv_tmp[ent+i] = kv_tmp[past+i];
      for (int i = NBYTES - (past - ent); i < NBYTES; i++) kv_tmp[i] = 8'h00;
      if (val_len == 0) begin
        for (int i = 0; i < NBYTES; i++) kv_mem[i] = kv_tmp[i];
        return ST_OK;
      end
    end
    f = 0;
    for (int i = NBYTES - 1; i >= 0; i--)
      if (kv_tmp[i] != 8'h00) begin
        f = i + 2;
        break;
      end
    need = key_len + val_len + 2;
    if (f > NBYTES || NBYTES - f < need) return ST_NOSPACE;
    for (int i = 0; i < key_len; i++) kv_tmp[f++] = upcase(key_buf[i]);
    kv_tmp[f++] = CH_EQ;
    for (int i = 0; i < val_len; i++) kv_tmp[f++] = val_buf[i];
    kv_tmp[f] = 8'h00;
    for (int i = 0; i < NBYTES; i++) kv_mem[i] = kv_tmp[i];
    return ST_OK;
  endfunction

  // Advance the shadow by one transaction and return its result
  function automatic pkvs_out_t predict_result(pkvs_in_t t);
    pkvs_out_t r;
    int ent, vpos, n, lim;
    r = '0;
    case (t.opcode)
      OP_KEY, OP_VAL: begin
        if (t.char_in != 8'h00) begin
          if (t.opcode == OP_KEY) begin
            if (key_len < KEY_CAP) key_buf[key_len++] = t.char_in;
            else begin stage_ovf = 1'b1; r.status = ST_BADKEY; end
          end else begin
            if (val_len < VAL_CAP) val_buf[val_len++] = t.char_in;
            else begin stage_ovf = 1'b1; r.status = ST_BADKEY; end
          end
        end
      end
      OP_GET, OP_SET: begin
        if (key_len == 0 || stage_ovf) r.status = ST_BADKEY;
        else if (t.opcode == OP_GET) begin
          if (lookup_key(ent, vpos)) begin
            n = value_span(vpos);
            lim = (t.buffer_len == 0) ? 0 : int'(t.buffer_len) - 1;
            if (n > lim) n = lim;
            if (n > 1023) n = 1023;
            r.value_offset = vpos[9:0];
            r.value_length = n[9:0];
          end else r.status = ST_NOTFOUND;
        end else r.status = apply_set();
        key_len = 0;
        val_len = 0;
        stage_ovf = 1'b0;
      end
      OP_LOAD: kv_mem[t.address] = t.char_in;
      OP_READ: r.read_byte = kv_mem[t.address];
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // Check results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) report_mismatch("unexpected result", 1, 0);
      else begin
        pkvs_out_t e;
        e = expected_q.pop_front();
        if (out_data_o.status != e.status)
          report_mismatch("status", out_data_o.status, e.status);
        if (out_data_o.value_offset != e.value_offset)
          report_mismatch("value_offset", out_data_o.value_offset, e.value_offset);
        if (out_data_o.value_length != e.value_length)
          report_mismatch("value_length", out_data_o.value_length, e.value_length);
        if (out_data_o.read_byte != e.read_byte)
          report_mismatch("read_byte", out_data_o.read_byte, e.read_byte);
      end
    end
  end

  // Watchdog on cycles without any accepted transaction or delivered result
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WD_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Random receiver stalls in bursts
  initial begin
    int burst;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 18);
        out_stall_i <= 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Drive one transaction: hold until accepted, then record its prediction
  task automatic send_item(pkvs_in_t t, bit has_want, pkvs_out_t want);
    pkvs_out_t p;
    in_data_i <= t;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    p = predict_result(t);
    if (has_want && p != want) report_mismatch("table row vs model", p, want);
    expected_q.push_back(p);
    sent++;
    @(negedge clk_i);
    if (!quiet_tail && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
  endtask

  function automatic pkvs_in_t mk(logic [2:0] op, logic [7:0] ch, logic [9:0] a = 0,
                                  logic [15:0] bl = 0);
    pkvs_in_t t;
    t.opcode = op;
    t.char_in = ch;
    t.address = a;
    t.buffer_len = bl;
    return t;
  endfunction

  function automatic pkvs_out_t res(logic [1:0] s, logic [9:0] o = 0,
                                    logic [9:0] l = 0, logic [7:0] b = 0);
    pkvs_out_t r;
    r.status = s;
    r.value_offset = o;
    r.value_length = l;
    r.read_byte = b;
    return r;
  endfunction

  typedef struct {
    pkvs_in_t  stim;
    bit        known;
    pkvs_out_t want;
  } row_t;

  row_t plan [$];

  // Stage a key and value and follow with a set or get
  task automatic send_pair(int klen, int vlen, bit do_get);
    for (int i = 0; i < klen; i++)
      send_item(mk(OP_KEY, ($urandom_range(0, 3) == 0) ? 8'(8'h61 + $urandom_range(0, 3))
                        : 8'(8'h41 + $urandom_range(0, 3))), 1'b0, '0);
    for (int i = 0; i < vlen; i++)
      send_item(mk(OP_VAL, 8'($urandom_range(1, 255))), 1'b0, '0);
    send_item(mk(do_get ? OP_GET : OP_SET, 8'd0, 10'd0, 16'($urandom_range(0, 65535))),
              1'b0, '0);
  endtask

  initial begin
    pkvs_in_t t;
    int sel;
    err_count = 0;
    quiet_tail = 1'b0;
    idle_cycles = 0;
    sent = 0;
    key_len = 0;
    val_len = 0;
    stage_ovf = 1'b0;
    for (int i = 0; i < NBYTES; i++) kv_mem[i] = 8'h00;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    plan.push_back('{mk(OP_READ, 0, 0), 1, res(ST_OK)});
    plan.push_back('{mk(OP_READ, 0, 10'h3ff), 1, res(ST_OK)});
    plan.push_back('{mk(OP_GET, 0), 1, res(ST_BADKEY)});
    plan.push_back('{mk(OP_SET, 0), 1, res(ST_BADKEY)});
    plan.push_back('{mk(OP_KEY, 8'h00), 1, res(ST_OK)});
    plan.push_back('{mk(OP_KEY, 8'h61), 0, '0});
    plan.push_back('{mk(OP_KEY, 8'h7a), 0, '0});
    plan.push_back('{mk(OP_VAL, 8'hff), 0, '0});
    plan.push_back('{mk(OP_VAL, 8'h00), 1, res(ST_OK)});
    plan.push_back('{mk(OP_SET, 0), 1, res(ST_OK)});
    plan.push_back('{mk(OP_KEY, 8'h41), 0, '0});
    plan.push_back('{mk(OP_KEY, 8'h5a), 0, '0});
    plan.push_back('{mk(OP_GET, 0, 0, 16'hffff), 1, res(ST_OK, 3, 1)});
    plan.push_back('{mk(OP_KEY, 8'h41), 0, '0});
    plan.push_back('{mk(OP_GET, 0, 0, 0), 1, res(ST_NOTFOUND)});
    plan.push_back('{mk(OP_KEY, 8'h61), 0, '0});
    plan.push_back('{mk(OP_KEY, 8'h5a), 0, '0});
    plan.push_back('{mk(OP_GET, 0, 0, 0), 1, res(ST_OK, 3, 0)});
    plan.push_back('{mk(OP_READ, 0, 2), 1, res(ST_OK, 0, 0, CH_EQ)});
    plan.push_back('{mk(OP_LOAD, 8'hff, 10'h3ff), 0, '0});
    plan.push_back('{mk(OP_READ, 0, 10'h3ff), 1, res(ST_OK, 0, 0, 8'hff)});
    plan.push_back('{mk(3'd6, 8'h55, 10'h2aa, 16'haaaa), 1, res(ST_OK)});
    plan.push_back('{mk(3'd7, 8'haa, 10'h155, 16'h5555), 1, res(ST_OK)});
    plan.push_back('{mk(OP_LOAD, 8'h00, 10'h3ff), 0, '0});
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    foreach (plan[i]) send_item(plan[i].stim, plan[i].known, plan[i].want);

    // Overflow the key stage, then try a set
    for (int i = 0; i <= KEY_CAP; i++) send_item(mk(OP_KEY, 8'h4b), 1'b0, '0);
    send_item(mk(OP_SET, 0), 1'b1, res(ST_BADKEY));

    // Hold off until the block has drained
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    @(negedge clk_i);

    // Random sequences: mostly well formed key/value/set/get runs
    while (sent < N_ITEMS) begin
      if (sent >= N_ITEMS - 40) quiet_tail = 1'b1;
      sel = $urandom_range(0, 9);
      if (sel < 4) send_pair($urandom_range(1, 3), $urandom_range(0, 4), 1'b0);
      else if (sel < 6) send_pair($urandom_range(1, 3), 0, 1'b1);
      else if (sel == 6) send_pair($urandom_range(8, 16), $urandom_range(20, 60), 1'b0);
      else if (sel == 7) begin
        t = mk(OP_READ, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
               16'($urandom_range(0, 65535)));
        if ($urandom_range(0, 3) == 0) t.address = 10'($urandom_range(0, 40));
        send_item(t, 1'b0, '0);
      end else if (sel == 8) begin
        t = mk(OP_LOAD, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)),
               16'($urandom_range(0, 65535)));
        if ($urandom_range(0, 1) == 0) t.char_in = 8'h00;
        send_item(t, 1'b0, '0);
      end else begin
        t = mk(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
               10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)));
        send_item(t, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    wait (expected_q.size() == 0);
    repeat (4000) @(posedge clk_i);
    if (err_count == 0 && expected_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pkvs_pkg.sv
hw/rtl/pkvs_stage.sv
hw/rtl/pkvs_store.sv
hw/rtl/packed_key_value_store.sv
hw/rtl/pkvs_checker.sv
tb/tb.sv
